[hw/rtl/akf_pkg.sv]
// ----------------------------------------------------------------------------
// akf_pkg
// Types, codes and saturating helpers for the altitude Kalman filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package akf_pkg;

	localparam int DT_W   = 16;
	localparam int NOISE_W = 32;
	localparam int SMP_W  = 32;
	localparam int EST_W  = 48;
	localparam int COV_W  = 64;
	localparam int CNT_W  = 7;

	localparam logic [1:0] REG_PERIOD = 2'd0;
	localparam logic [1:0] REG_QNOISE = 2'd1;
	localparam logic [1:0] REG_RNOISE = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	// Microprogram steps, run in order from SP_POS_DT.
	typedef enum logic [4:0] {
		SP_POS_DT,
		SP_VEL_DT,
		SP_DT_SQ,
		SP_CROSS_DT,
		SP_VV_DT2,
		SP_VV_DT,
		SP_PRED_COV,
		SP_DEN,
		SP_GAIN1,
		SP_GAIN2,
		SP_CORR_VEL,
		SP_CORR_POS,
		SP_UPD_VV,
		SP_UPD_VP,
		SP_UPD_PV,
		SP_UPD_PP,
		SP_LAST
	} step_t;

	// Product shift after the multiply.
	typedef enum logic [1:0] {
		SH_NONE,
		SH_DT,
		SH_GAIN
	} sh_t;

	typedef struct packed {
		logic             go_mul;
		logic             go_div;
		logic signed [63:0] opa;
		logic signed [63:0] opb;
		sh_t              sh;
	} launch_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		mag64 = v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			sat_add = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			sat_add = s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			sat_sub = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			sat_sub = s[63:0];
	endfunction

	function automatic logic signed [EST_W-1:0] clamp_est(input logic signed [63:0] v);
		if (v[63:EST_W-1] == '0 || v[63:EST_W-1] == '1)
			clamp_est = v[EST_W-1:0];
		else
			clamp_est = v[63] ? {1'b1, {(EST_W-1){1'b0}}} : {1'b0, {(EST_W-1){1'b1}}};
	endfunction

	function automatic logic signed [SMP_W-1:0] out32(input logic signed [EST_W-1:0] v);
		if (v[EST_W-1:SMP_W-1] == '0 || v[EST_W-1:SMP_W-1] == '1)
			out32 = v[SMP_W-1:0];
		else
			out32 = v[EST_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
	endfunction

	// Sign a 128-bit magnitude and saturate to 64 bits.
	function automatic logic signed [63:0] signed_sat(input logic neg,
		input logic [127:0] m);
		logic big;
		big = (m[127:63] != '0);
		if (neg)
			signed_sat = big ? {1'b1, 63'd0} : (64'd0 - m[63:0]);
		else
			signed_sat = big ? {1'b0, {63{1'b1}}} : m[63:0];
	endfunction

endpackage

`default_nettype wire

[hw/rtl/altitude_kalman_filter_core.sv]
// ----------------------------------------------------------------------------
// altitude_kalman_filter_core
// Two-state (position, velocity) fixed-point Kalman filter, bit-serial datapath.
// ----------------------------------------------------------------------------
// One input beat gives one output beat. A normal update runs twelve products
// on a shared shift-add multiplier that retires one multiplier bit per cycle
// and two gain quotients on a restoring divider that retires one quotient bit
// per cycle, with one issue state per microprogram step; the result is then
// loaded into the output register once that register is free. A clear beat
// goes straight to that output load. One beat is worked on at a time; in_ready
// is high while the core is idle, and a finished result sits in the output
// register until taken, so the next beat may be accepted meanwhile.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and
// must only be made while the core is idle.
// FRAC_BITS sets the fraction bits of the noise values.
`default_nettype none

module altitude_kalman_filter_core #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [31:0] measured_position,
	input  wire logic signed [31:0] acceleration,
	input  wire logic        clear_state,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] estimated_position,
	output logic signed [31:0] estimated_velocity
);

	// Configuration registers
	logic [akf_pkg::DT_W-1:0]    dt_q;
	logic [akf_pkg::NOISE_W-1:0] qn_q;
	logic [akf_pkg::NOISE_W-1:0] rn_q;

	// Filter state
	logic signed [akf_pkg::EST_W-1:0] pos_q, vel_q;
	logic signed [63:0] c11_q, c12_q, c21_q, c22_q;

	// Scratch for one update
	logic signed [31:0] smp_q, acc_q;
	logic signed [63:0] p11_q, p12_q, p21_q, p22_q;
	logic signed [63:0] tmp_q, dt2_q, den_q, k1_q, k2_q, innov_q, res_q;

	// Sequencer
	akf_pkg::state_t state_q, state_d;
	akf_pkg::step_t  step_q;
	akf_pkg::launch_t ln;

	// Shared serial units
	logic [127:0]  mp_q;     // multiplier: product high / multiplier low
	logic [63:0]   ma_q;     // multiplicand magnitude
	logic [127:0]  dd_q;     // divider: dividend in, quotient out
	logic [63:0]   rem_q;
	logic [63:0]   dv_q;
	logic          neg_q;
	logic          zdiv_q;
	akf_pkg::sh_t  sh_q;
	logic [akf_pkg::CNT_W-1:0] cnt_q;

	logic [64:0]   mul_sum;
	logic [127:0]  mp_next;
	logic [64:0]   div_r;
	logic          div_ge;
	logic [127:0]  mul_shifted;
	logic signed [63:0] mul_res, div_res;
	logic signed [63:0] qc, rc, vel_x, pos_x;
	logic signed [63:0] dt_x;
	logic          in_beat, done_load;

	assign in_beat   = in_valid && in_ready;
	assign in_ready  = (state_q == akf_pkg::ST_IDLE);
	assign done_load = (state_q == akf_pkg::ST_DONE) && (!out_valid || out_ready);

	assign qc    = {32'd0, qn_q} << FRAC_BITS;
	assign rc    = {32'd0, rn_q} << FRAC_BITS;
	assign vel_x = {{(64-akf_pkg::EST_W){vel_q[akf_pkg::EST_W-1]}}, vel_q};
	assign pos_x = {{(64-akf_pkg::EST_W){pos_q[akf_pkg::EST_W-1]}}, pos_q};
	assign dt_x  = {{(64-akf_pkg::DT_W){1'b0}}, dt_q};

	// --- serial arithmetic ---------------------------------------------------
	// Multiply: add multiplicand into the high half when the low bit is set,
	// then shift right one place.
	assign mul_sum = {1'b0, mp_q[127:64]} + (mp_q[0] ? {1'b0, ma_q} : 65'd0);
	assign mp_next = {mul_sum, mp_q[63:1]};

	// Restoring divide: one quotient bit per cycle.
	assign div_r  = {rem_q, dd_q[127]};
	assign div_ge = (div_r >= {1'b0, dv_q});

	// Shift of the product as it stands after this cycle's step.
	always_comb begin
		case (sh_q)
			akf_pkg::SH_DT:   mul_shifted = mp_next >> akf_pkg::DT_W;
			akf_pkg::SH_GAIN: mul_shifted = mp_next >> 32;
			default:          mul_shifted = mp_next;
		endcase
	end

	assign mul_res = akf_pkg::signed_sat(neg_q, mul_shifted);
	assign div_res = zdiv_q ? 64'sd0 : akf_pkg::signed_sat(neg_q, dd_q);

	// --- operand selection for each microprogram step ------------------------
	always_comb begin
		ln = '{go_mul: 1'b0, go_div: 1'b0, opa: 64'sd0, opb: 64'sd0,
			sh: akf_pkg::SH_NONE};
		case (step_q)
			akf_pkg::SP_POS_DT: begin
				ln.go_mul = 1'b1; ln.opa = vel_x; ln.opb = dt_x; ln.sh = akf_pkg::SH_DT;
			end
			akf_pkg::SP_VEL_DT: begin
				ln.go_mul = 1'b1; ln.opa = 64'(acc_q); ln.opb = dt_x;
				ln.sh = akf_pkg::SH_DT;
			end
			akf_pkg::SP_DT_SQ: begin
				ln.go_mul = 1'b1; ln.opa = dt_x; ln.opb = dt_x; ln.sh = akf_pkg::SH_NONE;
			end
			akf_pkg::SP_CROSS_DT: begin
				ln.go_mul = 1'b1; ln.opa = akf_pkg::sat_add(c12_q, c21_q); ln.opb = dt_x;
				ln.sh = akf_pkg::SH_DT;
			end
			akf_pkg::SP_VV_DT2: begin
				ln.go_mul = 1'b1; ln.opa = c22_q; ln.opb = dt2_q; ln.sh = akf_pkg::SH_GAIN;
			end
			akf_pkg::SP_VV_DT: begin
				ln.go_mul = 1'b1; ln.opa = c22_q; ln.opb = dt_x; ln.sh = akf_pkg::SH_DT;
			end
			akf_pkg::SP_GAIN1: begin
				ln.go_div = 1'b1; ln.opa = p11_q; ln.opb = den_q;
			end
			akf_pkg::SP_GAIN2: begin
				ln.go_div = 1'b1; ln.opa = p21_q; ln.opb = den_q;
			end
			akf_pkg::SP_CORR_VEL: begin
				ln.go_mul = 1'b1; ln.opa = res_q;
				ln.opb = 64'(smp_q) - pos_x; ln.sh = akf_pkg::SH_GAIN;
			end
			akf_pkg::SP_CORR_POS: begin
				ln.go_mul = 1'b1; ln.opa = k1_q; ln.opb = innov_q; ln.sh = akf_pkg::SH_GAIN;
			end
			akf_pkg::SP_UPD_VV: begin
				ln.go_mul = 1'b1; ln.opa = k2_q; ln.opb = p12_q; ln.sh = akf_pkg::SH_GAIN;
			end
			akf_pkg::SP_UPD_VP: begin
				ln.go_mul = 1'b1; ln.opa = k2_q; ln.opb = p11_q; ln.sh = akf_pkg::SH_GAIN;
			end
			akf_pkg::SP_UPD_PV: begin
				ln.go_mul = 1'b1; ln.opa = k1_q; ln.opb = p12_q; ln.sh = akf_pkg::SH_GAIN;
			end
			akf_pkg::SP_UPD_PP: begin
				ln.go_mul = 1'b1; ln.opa = k1_q; ln.opb = p11_q; ln.sh = akf_pkg::SH_GAIN;
			end
			default: ;
		endcase
	end

	// --- next state ----------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			akf_pkg::ST_IDLE:
				if (in_beat)
					state_d = clear_state ? akf_pkg::ST_DONE : akf_pkg::ST_ISSUE;
			akf_pkg::ST_ISSUE: begin
				if (step_q == akf_pkg::SP_LAST)
					state_d = akf_pkg::ST_DONE;
				else if (ln.go_mul)
					state_d = akf_pkg::ST_MUL;
				else if (ln.go_div)
					state_d = akf_pkg::ST_DIV;
			end
			akf_pkg::ST_MUL, akf_pkg::ST_DIV:
				if (cnt_q == '0)
					state_d = akf_pkg::ST_ISSUE;
			akf_pkg::ST_DONE:
				if (done_load)
					state_d = akf_pkg::ST_IDLE;
			default: state_d = akf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= akf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// --- control registers: config, state, step, output valid ---------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q      <= akf_pkg::DT_W'(655);
			qn_q      <= akf_pkg::NOISE_W'(65536);
			rn_q      <= akf_pkg::NOISE_W'(65536);
			pos_q     <= '0;
			vel_q     <= '0;
			c11_q     <= '0;
			c12_q     <= '0;
			c21_q     <= '0;
			c22_q     <= '0;
			step_q    <= akf_pkg::SP_POS_DT;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					akf_pkg::REG_PERIOD: dt_q <= cfg_data[akf_pkg::DT_W-1:0];
					akf_pkg::REG_QNOISE: qn_q <= cfg_data;
					akf_pkg::REG_RNOISE: rn_q <= cfg_data;
					default: ;
				endcase
			end

			if (in_beat) begin
				step_q <= akf_pkg::SP_POS_DT;
				if (clear_state) begin
					pos_q <= '0;
					vel_q <= '0;
					c11_q <= '0;
					c12_q <= '0;
					c21_q <= '0;
					c22_q <= '0;
				end
			end

			if (state_q == akf_pkg::ST_MUL || state_q == akf_pkg::ST_DIV)
				cnt_q <= cnt_q - 1'b1;

			if (state_q == akf_pkg::ST_ISSUE) begin
				if (step_q != akf_pkg::SP_LAST)
					step_q <= akf_pkg::step_t'(step_q + 1'b1);
				if (ln.go_mul)
					cnt_q <= akf_pkg::CNT_W'(63);
				else if (ln.go_div)
					cnt_q <= akf_pkg::CNT_W'(127);
				case (step_q)
					akf_pkg::SP_VEL_DT:
						pos_q <= akf_pkg::clamp_est(akf_pkg::sat_add(pos_x, res_q));
					akf_pkg::SP_DT_SQ:
						vel_q <= akf_pkg::clamp_est(akf_pkg::sat_add(vel_x, res_q));
					akf_pkg::SP_CORR_POS:
						vel_q <= akf_pkg::clamp_est(akf_pkg::sat_add(vel_x, res_q));
					akf_pkg::SP_UPD_VV:
						pos_q <= akf_pkg::clamp_est(akf_pkg::sat_add(pos_x, res_q));
					akf_pkg::SP_UPD_VP: c22_q <= akf_pkg::sat_sub(p22_q, res_q);
					akf_pkg::SP_UPD_PV: c21_q <= akf_pkg::sat_sub(p21_q, res_q);
					akf_pkg::SP_UPD_PP: c12_q <= akf_pkg::sat_sub(p12_q, res_q);
					akf_pkg::SP_LAST:   c11_q <= akf_pkg::sat_sub(p11_q, res_q);
					default: ;
				endcase
			end

			if (done_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	// --- datapath registers --------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_beat) begin
			smp_q <= measured_position;
			acc_q <= acceleration;
		end

		if (state_q == akf_pkg::ST_MUL) begin
			mp_q <= mp_next;
			if (cnt_q == '0)
				res_q <= mul_res;
		end
		if (state_q == akf_pkg::ST_DIV) begin
			rem_q <= div_ge ? 64'(div_r - {1'b0, dv_q}) : div_r[63:0];
			dd_q  <= {dd_q[126:0], div_ge};
		end

		if (state_q == akf_pkg::ST_ISSUE) begin
			if (ln.go_mul) begin
				mp_q  <= {64'd0, akf_pkg::mag64(ln.opb)};
				ma_q  <= akf_pkg::mag64(ln.opa);
				neg_q <= ln.opa[63] ^ ln.opb[63];
				sh_q  <= ln.sh;
			end
			if (ln.go_div) begin
				dd_q   <= {32'd0, akf_pkg::mag64(ln.opa), 32'd0};
				rem_q  <= '0;
				dv_q   <= akf_pkg::mag64(ln.opb);
				neg_q  <= ln.opa[63] ^ ln.opb[63];
				zdiv_q <= (ln.opb == 64'sd0);
			end
			case (step_q)
				akf_pkg::SP_CROSS_DT: dt2_q <= res_q;
				akf_pkg::SP_VV_DT2:   tmp_q <= res_q;
				akf_pkg::SP_VV_DT:    tmp_q <= akf_pkg::sat_add(tmp_q, res_q);
				akf_pkg::SP_PRED_COV: begin
					p11_q <= akf_pkg::sat_add(c11_q, tmp_q);
					p12_q <= akf_pkg::sat_add(c12_q, res_q);
					p21_q <= akf_pkg::sat_add(c21_q, res_q);
					p22_q <= akf_pkg::sat_add(c22_q, qc);
				end
				akf_pkg::SP_DEN:      den_q <= akf_pkg::sat_add(p11_q, rc);
				akf_pkg::SP_GAIN2:    k1_q <= res_q;
				akf_pkg::SP_CORR_VEL: begin
					k2_q    <= res_q;
					innov_q <= 64'(smp_q) - pos_x;
				end
				default: ;
			endcase
		end
		if (state_q == akf_pkg::ST_DIV && cnt_q == '0)
			res_q <= zdiv_q ? 64'sd0
				: akf_pkg::signed_sat(neg_q, {dd_q[126:0], div_ge});

		if (done_load) begin
			estimated_position <= akf_pkg::out32(pos_q);
			estimated_velocity <= akf_pkg::out32(vel_q);
		end
	end

	// --- assertions ----------------------------------------------------------
	// The core takes no second beat while one is in flight.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !in_ready)
		else $error("input taken while busy");

	// A clear beat leaves position, velocity and the diagonal covariance terms at zero.
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && clear_state) |=> (pos_q == '0 && vel_q == '0 && c11_q == '0
			&& c22_q == '0))
		else $error("clear did not zero state");

	// The multiplier never runs longer than one word of multiplier bits.
	a_mul_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == akf_pkg::ST_MUL) |-> (cnt_q < akf_pkg::CNT_W'(64)))
		else $error("multiplier count out of range");

	// A zero divisor yields a zero gain.
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == akf_pkg::ST_DIV && cnt_q == '0 && zdiv_q) |-> (div_res == 64'sd0))
		else $error("zero divisor gave nonzero gain");

endmodule

`default_nettype wire

[test/altitude_kalman_filter_checker.sv]
// ----------------------------------------------------------------------------
// altitude_kalman_filter_checker
// Watches the configuration port and both streams of the altitude Kalman
// filter core, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module altitude_kalman_filter_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic signed [31:0] measured_position,
	input  wire logic signed [31:0] acceleration,
	input  wire logic        clear_state,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic signed [31:0] estimated_position,
	input  wire logic signed [31:0] estimated_velocity,
	output int               errors,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};
	localparam logic signed [63:0] ALT_MAX = 64'sd140737488355327;
	localparam logic signed [63:0] ALT_MIN = -64'sd140737488355328;
	localparam logic signed [63:0] W32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] W32_MIN = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
	} estimate_t;

	estimate_t estimates_due[$];

	logic [15:0] dt_reg;
	logic [31:0] q_reg, r_reg;
	logic signed [63:0] alt, climb, c11, c12, c21, c22;

	function automatic logic [63:0] absval(input logic signed [63:0] v);
		return v[63] ? 64'd0 - v : v;
	endfunction

	function automatic logic signed [63:0] limit_signed(input logic neg, input logic [127:0] m);
		if (neg)
			return (m >= 128'h8000_0000_0000_0000) ? S64_MIN : 64'd0 - m[63:0];
		return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? S64_MAX : m[63:0];
	endfunction

	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
		input logic signed [63:0] b, input int sh);
		logic [127:0] m;
		m = {64'd0, absval(a)} * {64'd0, absval(b)};
		return limit_signed(a[63] ^ b[63], m >> sh);
	endfunction

	function automatic logic signed [63:0] fx_gain(input logic signed [63:0] num,
		input logic signed [63:0] den);
		logic [127:0] m;
		if (den == 0)
			return 0;
		m = ({64'd0, absval(num)} << 32) / {64'd0, absval(den)};
		return limit_signed(num[63] ^ den[63], m);
	endfunction

	function automatic logic signed [63:0] add_s(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(S64_MAX)) return S64_MAX;
		if (s < 65'(S64_MIN)) return S64_MIN;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sub_s(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) - 65'(b);
		if (s > 65'(S64_MAX)) return S64_MAX;
		if (s < 65'(S64_MIN)) return S64_MIN;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] bound(input logic signed [63:0] v,
		input logic signed [63:0] lo, input logic signed [63:0] hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// One filter update; returns the estimate beat it produces.
	function automatic estimate_t filter_update(input logic signed [31:0] z,
		input logic signed [31:0] acc, input logic clr);
		logic signed [63:0] dt, qs, rs, p11, p12, p21, p22, den, k1, k2, innov;
		estimate_t e;
		dt = {48'd0, dt_reg};
		qs = {16'd0, q_reg, 16'd0};
		rs = {16'd0, r_reg, 16'd0};
		if (clr) begin
			alt = 0; climb = 0; c11 = 0; c12 = 0; c21 = 0; c22 = 0;
			e.pos = 0;
			e.vel = 0;
			return e;
		end
		alt = bound(add_s(alt, fx_mul(climb, dt, 16)), ALT_MIN, ALT_MAX);
		climb = bound(add_s(climb, fx_mul(64'(acc), dt, 16)), ALT_MIN, ALT_MAX);
		p11 = add_s(c11, add_s(fx_mul(add_s(c12, c21), dt, 16), fx_mul(c22, dt * dt, 32)));
		p12 = add_s(c12, fx_mul(c22, dt, 16));
		p21 = add_s(c21, fx_mul(c22, dt, 16));
		p22 = add_s(c22, qs);
		den = add_s(p11, rs);
		k1 = fx_gain(p11, den);
		k2 = fx_gain(p21, den);
		innov = 64'(z) - alt;
		climb = bound(add_s(climb, fx_mul(k2, innov, 32)), ALT_MIN, ALT_MAX);
		alt = bound(add_s(alt, fx_mul(k1, innov, 32)), ALT_MIN, ALT_MAX);
		c22 = sub_s(p22, fx_mul(k2, p12, 32));
		c21 = sub_s(p21, fx_mul(k2, p11, 32));
		c12 = sub_s(p12, fx_mul(k1, p12, 32));
		c11 = sub_s(p11, fx_mul(k1, p11, 32));
		e.pos = 32'(bound(alt, W32_MIN, W32_MAX));
		e.vel = 32'(bound(climb, W32_MIN, W32_MAX));
		return e;
	endfunction

	assign outstanding = estimates_due.size();

	always @(posedge clk or negedge arst_n) begin
		estimate_t want;
		int bad;
		if (!arst_n) begin
			dt_reg <= 16'd655;
			q_reg <= 32'd65536;
			r_reg <= 32'd65536;
			alt = 0; climb = 0; c11 = 0; c12 = 0; c21 = 0; c22 = 0;
			estimates_due.delete();
			errors <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				case (cfg_index)
					akf_pkg::REG_PERIOD: dt_reg <= cfg_data[15:0];
					akf_pkg::REG_QNOISE: q_reg <= cfg_data;
					akf_pkg::REG_RNOISE: r_reg <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				estimates_due.push_back(filter_update(measured_position, acceleration,
					clear_state));
			if (out_valid && out_ready) begin
				if (estimates_due.size() == 0) begin
					$error("unexpected estimate beat pos=%0d vel=%0d",
						estimated_position, estimated_velocity);
					bad = bad + 1;
				end else begin
					want = estimates_due.pop_front();
					if (estimated_position !== want.pos) begin
						$error("estimated_position expected %0d got %0d", want.pos,
							estimated_position);
						bad = bad + 1;
					end
					if (estimated_velocity !== want.vel) begin
						$error("estimated_velocity expected %0d got %0d", want.vel,
							estimated_velocity);
						bad = bad + 1;
					end
				end
			end
			if (bad != 0)
				errors <= errors + bad;
		end
	end

endmodule

`default_nettype wire

[test/tb_altitude_kalman_filter_core.sv]
// ----------------------------------------------------------------------------
// tb_altitude_kalman_filter_core
// Drives directed and random beats through the altitude Kalman filter core
// under several register settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_altitude_kalman_filter_core;
	timeunit 1ns;
	timeprecision 1ps;

	// Index with no register behind it; writes there must be ignored.
	localparam logic [1:0] REG_SPARE = 2'd3;
	// About 510 beats plus stalls stay far below this cycle limit.
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE = 1200;

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [31:0] measured_position, acceleration;
	logic clear_state;
	logic out_valid, out_ready;
	logic signed [31:0] estimated_position, estimated_velocity;
	int errors, outstanding;
	int cycles;
	bit idle_on;     // random stalls on both streams
	bit hold_out;    // request a long receiver hold-off

	altitude_kalman_filter_core uut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .measured_position, .acceleration, .clear_state,
		.out_valid, .out_ready, .estimated_position, .estimated_velocity
	);

	altitude_kalman_filter_checker chk (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .measured_position, .acceleration, .clear_state,
		.out_valid, .out_ready, .estimated_position, .estimated_velocity,
		.errors, .outstanding
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("altitude_kalman_filter_core verification failed");
			$finish;
		end
	end

	// Receiver: random short stalls, one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				repeat (4000) @(posedge clk);
				hold_out = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// One input beat; returns on the edge that accepts it, valid still high.
	task automatic send_beat(input logic signed [31:0] z, input logic signed [31:0] acc,
		input logic clr);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		measured_position <= z;
		acceleration <= acc;
		clear_state <= clr;
		do @(posedge clk); while (!in_ready);
	endtask

	// Close the input stream and let every estimate drain.
	task automatic drain;
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random sample: mostly moderate altitudes, some full-range values.
	function automatic logic signed [31:0] pick_sample();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
			default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
		endcase
	endfunction

	task automatic random_run(input int n);
		repeat (n)
			send_beat(pick_sample(), pick_sample(), $urandom_range(0, 24) == 0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = akf_pkg::REG_PERIOD;
		cfg_data = '0;
		in_valid = 1'b0;
		measured_position = '0;
		acceleration = '0;
		clear_state = 1'b0;
		cycles = 0;
		idle_on = 1'b1;
		hold_out = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset settings, field extremes, clear requests.
		send_beat(32'sd0, 32'sd0, 1'b0);
		send_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_beat(32'sh8000_0000, 32'sh8000_0000, 1'b0);
		send_beat(32'sh0001_0000, -32'sh0001_0000, 1'b0);
		send_beat(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);  // clear ignores payload
		send_beat(32'sh1234_5678, 32'sh0000_0001, 1'b0);
		drain();

		// Zero measurement noise right after a clear: zero denominator, zero gain.
		write_reg(akf_pkg::REG_RNOISE, 32'd0);
		write_reg(akf_pkg::REG_QNOISE, 32'd0);
		send_beat(32'sd0, 32'sd0, 1'b1);
		send_beat(32'sh0010_0000, 32'sh0002_0000, 1'b0);
		send_beat(-32'sh0010_0000, 32'sh0002_0000, 1'b0);
		drain();

		// Zero period freezes the prediction; huge noise pushes saturation.
		write_reg(akf_pkg::REG_PERIOD, 32'd0);
		write_reg(akf_pkg::REG_QNOISE, 32'hFFFF_FFFF);
		write_reg(akf_pkg::REG_RNOISE, 32'hFFFF_FFFF);
		write_reg(REG_SPARE, 32'hDEAD_BEEF);
		send_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_beat(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
		drain();
		write_reg(akf_pkg::REG_PERIOD, 32'hFFFF_FFFF);  // upper half must be dropped
		repeat (6) send_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_beat(32'sh8000_0000, 32'sh8000_0000, 1'b0);
		drain();

		// Random phases across settings, extremes included.
		write_reg(akf_pkg::REG_PERIOD, 32'd655);
		write_reg(akf_pkg::REG_QNOISE, 32'd65536);
		write_reg(akf_pkg::REG_RNOISE, 32'd65536);
		random_run(100);
		// Long receiver hold-off while beats keep coming: input stalls.
		hold_out = 1'b1;
		random_run(20);
		drain();  // sender pause until every estimate is back

		write_reg(akf_pkg::REG_PERIOD, 32'd66);
		write_reg(akf_pkg::REG_QNOISE, 32'd0);
		write_reg(akf_pkg::REG_RNOISE, 32'd1);
		random_run(90);
		drain();

		write_reg(akf_pkg::REG_PERIOD, 32'd65535);
		write_reg(akf_pkg::REG_QNOISE, $urandom);
		write_reg(akf_pkg::REG_RNOISE, 32'hFFFF_FFFF);
		random_run(90);
		drain();

		write_reg(akf_pkg::REG_PERIOD, $urandom_range(66, 65535));
		write_reg(akf_pkg::REG_QNOISE, $urandom_range(0, 32'h000F_FFFF));
		write_reg(akf_pkg::REG_RNOISE, $urandom_range(1, 32'h000F_FFFF));
		random_run(90);
		drain();

		// Final stretch without any idling.
		idle_on = 1'b0;
		write_reg(akf_pkg::REG_PERIOD, 32'd655);
		write_reg(akf_pkg::REG_QNOISE, $urandom);
		write_reg(akf_pkg::REG_RNOISE, $urandom);
		random_run(100);
		drain();
		repeat (SETTLE) @(posedge clk);

		if (errors == 0)
			$display("altitude_kalman_filter_core verification clean");
		else
			$display("altitude_kalman_filter_core verification failed");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
hw/rtl/akf_pkg.sv
hw/rtl/altitude_kalman_filter_core.sv
test/altitude_kalman_filter_checker.sv
test/tb_altitude_kalman_filter_core.sv
